// ===== src/rgb_to_hsv_converter_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HSV_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb_to_hsv_converter: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HSV_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb_to_hsv_converter: check failed");

`endif

// ===== src/hsv_pkg.sv =====
package hsv_pkg;

	localparam int CHANNEL_BITS  = 8;
	localparam int HUE_FRAC_BITS = 6;

	localparam int HUE_BITS   = 9 + HUE_FRAC_BITS;
	localparam int SAT_FRAC   = 15;
	localparam int SAT_BITS   = SAT_FRAC + 1;
	localparam int HUE_SCALE  = 60 * (2 ** HUE_FRAC_BITS);
	localparam int T_BITS     = CHANNEL_BITS + 3;

	localparam int DIV_QW      = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;
	localparam int DIV_NW      = CHANNEL_BITS + DIV_QW;
	localparam int DIV_BASE    = 2;
	localparam int PIPE_STAGES = DIV_QW + DIV_BASE;

	localparam logic [SAT_BITS-1:0] SAT_ONE  = SAT_BITS'(1) << SAT_FRAC;
	localparam logic [HUE_BITS-1:0] HUE_FULL = HUE_BITS'(360 * (2 ** HUE_FRAC_BITS));

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HUE_BITS-1:0]     hue;
		logic [SAT_BITS-1:0]     saturation;
		logic [CHANNEL_BITS-1:0] brightness;
	} hsv_t;

	typedef enum logic [2:0] {
		SEC_RED   = 3'b001,
		SEC_GREEN = 3'b010,
		SEC_BLUE  = 3'b100
	} sector_t;

	typedef struct packed {
		logic [DIV_NW-1:0]       num;
		logic [CHANNEL_BITS-1:0] den;
	} div_op_t;

	typedef struct packed {
		div_op_t                 hue_op;
		div_op_t                 sat_op;
		logic [CHANNEL_BITS-1:0] brightness;
	} prep_out_t;

	typedef struct packed {
		logic [PIPE_STAGES-1:0] en;
	} pipe_ctl_t;

endpackage

// ===== src/rgb_to_hsv_converter.sv =====
// RGB to HSV converter: one pixel beat in and one HSV beat out per clock while hsv_ready is high.
// Two stages find max, min, sector and the division operands, then saturation and hue
// each go through a pipelined restoring divider that settles one quotient bit per stage,
// and the last divider stage is the output register. Stages with no beat in them close
// up while the output is stalled, so input keeps being taken until the whole pipeline is
// full. Hue is degrees times 64 (floor, 0 for gray), saturation is Q1.15 (floor, 32768
// is 1.0), brightness is the largest channel.
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pix_valid,
	output logic          pix_ready,
	input  hsv_pkg::rgb_t pix,
	output logic          hsv_valid,
	input  logic          hsv_ready,
	output hsv_pkg::hsv_t hsv
);

	hsv_pkg::pipe_ctl_t               ctl;
	hsv_pkg::prep_out_t               prep;
	logic [hsv_pkg::DIV_QW-1:0]       hue_quo, sat_quo;
	logic [hsv_pkg::CHANNEL_BITS-1:0] bright_s [hsv_pkg::DIV_QW];

	hsv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.ctl       (ctl)
	);

	hsv_prep u_prep (
		.clk (clk),
		.ctl (ctl),
		.pix (pix),
		.res (prep)
	);

	hsv_div u_div_hue (
		.clk (clk),
		.ctl (ctl),
		.op  (prep.hue_op),
		.quo (hue_quo)
	);

	hsv_div u_div_sat (
		.clk (clk),
		.ctl (ctl),
		.op  (prep.sat_op),
		.quo (sat_quo)
	);

	always_ff @(posedge clk) begin
		if (ctl.en[hsv_pkg::DIV_BASE]) begin
			bright_s[0] <= prep.brightness;
		end
		for (int j = 1; j < hsv_pkg::DIV_QW; j++) begin
			if (ctl.en[hsv_pkg::DIV_BASE + j]) begin
				bright_s[j] <= bright_s[j-1];
			end
		end
	end

	assign hsv.hue        = hue_quo[hsv_pkg::HUE_BITS-1:0];
	assign hsv.saturation = sat_quo[hsv_pkg::SAT_BITS-1:0];
	assign hsv.brightness = bright_s[hsv_pkg::DIV_QW-1];

	`HSV_ASSERT_IMP(a_black_is_zero, hsv_valid && hsv.brightness == '0, hsv.saturation == '0 && hsv.hue == '0)
	`HSV_ASSERT_IMP(a_sat_in_range, hsv_valid, hsv.saturation <= hsv_pkg::SAT_ONE)
	`HSV_ASSERT_IMP(a_hue_in_range, hsv_valid, hsv.hue < hsv_pkg::HUE_FULL)

endmodule

// ===== src/hsv_ctrl.sv =====
`include "rgb_to_hsv_converter_macros.svh"

module hsv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_ready,
	output logic               hsv_valid,
	input  logic               hsv_ready,
	output hsv_pkg::pipe_ctl_t ctl
);

	logic [hsv_pkg::PIPE_STAGES-1:0] valid_s;
	logic [hsv_pkg::PIPE_STAGES-1:0] load;

	// A stage may load when the output drains or any stage at or after it holds a bubble.
	always_comb begin
		for (int k = 0; k < hsv_pkg::PIPE_STAGES; k++) begin
			load[k] = hsv_ready ||
				((~valid_s & ({hsv_pkg::PIPE_STAGES{1'b1}} << k)) != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (load[0]) begin
				valid_s[0] <= pix_valid;
			end
			for (int k = 1; k < hsv_pkg::PIPE_STAGES; k++) begin
				if (load[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	assign pix_ready = load[0];
	assign hsv_valid = valid_s[hsv_pkg::PIPE_STAGES-1];
	assign ctl.en    = load;

	`HSV_ASSERT_NXT(a_accept_fills_first, pix_valid && pix_ready, valid_s[0])
	`HSV_ASSERT_IMP(a_bubble_gives_ready, !(&valid_s), pix_ready)

endmodule

// ===== src/hsv_prep.sv =====
module hsv_prep (
	input  logic                 clk,
	input  hsv_pkg::pipe_ctl_t   ctl,
	input  hsv_pkg::rgb_t        pix,
	output hsv_pkg::prep_out_t   res
);

	logic [hsv_pkg::CHANNEL_BITS-1:0] mx, mn, mn_rg;
	hsv_pkg::sector_t                 sec;
	logic [hsv_pkg::T_BITS-1:0]       diff;
	logic                             wrap;

	logic [hsv_pkg::CHANNEL_BITS-1:0] mx_s1, mn_s1;
	hsv_pkg::sector_t                 sec_s1;
	logic [hsv_pkg::T_BITS-1:0]       diff_s1;
	logic                             wrap_s1;

	logic [hsv_pkg::CHANNEL_BITS-1:0] delta;
	logic [hsv_pkg::T_BITS-1:0]       dext, base, t;
	hsv_pkg::prep_out_t               nx;
	hsv_pkg::prep_out_t               res_s2;

	always_comb begin
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			sec = hsv_pkg::SEC_RED;
			mx  = pix.red;
		end else if (pix.green >= pix.blue) begin
			sec = hsv_pkg::SEC_GREEN;
			mx  = pix.green;
		end else begin
			sec = hsv_pkg::SEC_BLUE;
			mx  = pix.blue;
		end
		mn_rg = (pix.red < pix.green) ? pix.red : pix.green;
		mn    = (mn_rg < pix.blue) ? mn_rg : pix.blue;
		unique case (sec)
			hsv_pkg::SEC_RED: begin
				diff = hsv_pkg::T_BITS'(pix.green) - hsv_pkg::T_BITS'(pix.blue);
				wrap = pix.green < pix.blue;
			end
			hsv_pkg::SEC_GREEN: begin
				diff = hsv_pkg::T_BITS'(pix.blue) - hsv_pkg::T_BITS'(pix.red);
				wrap = 1'b0;
			end
			hsv_pkg::SEC_BLUE: begin
				diff = hsv_pkg::T_BITS'(pix.red) - hsv_pkg::T_BITS'(pix.green);
				wrap = 1'b0;
			end
			default: begin
				diff = '0;
				wrap = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			mx_s1   <= mx;
			mn_s1   <= mn;
			sec_s1  <= sec;
			diff_s1 <= diff;
			wrap_s1 <= wrap;
		end
	end

	// The hue numerator is taken modulo 2^T_BITS; its true value is below 6*delta, and 0 for gray.
	always_comb begin
		delta = mx_s1 - mn_s1;
		dext  = hsv_pkg::T_BITS'(delta);
		unique case (sec_s1)
			hsv_pkg::SEC_RED:   base = wrap_s1 ? ((dext << 2) + (dext << 1)) : '0;
			hsv_pkg::SEC_GREEN: base = dext << 1;
			hsv_pkg::SEC_BLUE:  base = dext << 2;
			default:            base = '0;
		endcase
		t = base + diff_s1;
		nx.hue_op.num = hsv_pkg::DIV_NW'(t) * hsv_pkg::DIV_NW'(hsv_pkg::HUE_SCALE);
		nx.hue_op.den = (delta == '0) ? hsv_pkg::CHANNEL_BITS'(1) : delta;
		nx.sat_op.num = hsv_pkg::DIV_NW'(delta) << hsv_pkg::SAT_FRAC;
		nx.sat_op.den = (mx_s1 == '0) ? hsv_pkg::CHANNEL_BITS'(1) : mx_s1;
		nx.brightness = mx_s1;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			res_s2 <= nx;
		end
	end

	assign res = res_s2;

endmodule

// ===== src/hsv_div.sv =====
module hsv_div (
	input  logic                       clk,
	input  hsv_pkg::pipe_ctl_t         ctl,
	input  hsv_pkg::div_op_t           op,
	output logic [hsv_pkg::DIV_QW-1:0] quo
);

	logic [hsv_pkg::DIV_NW-1:0]       acc_in [hsv_pkg::DIV_QW];
	logic [hsv_pkg::CHANNEL_BITS-1:0] den_in [hsv_pkg::DIV_QW];
	logic [hsv_pkg::DIV_NW-1:0]       acc_nx [hsv_pkg::DIV_QW];
	logic [hsv_pkg::CHANNEL_BITS:0]   trial  [hsv_pkg::DIV_QW];
	logic [hsv_pkg::CHANNEL_BITS:0]   rem    [hsv_pkg::DIV_QW];
	logic                             ge     [hsv_pkg::DIV_QW];

	logic [hsv_pkg::DIV_NW-1:0]       acc_s  [hsv_pkg::DIV_QW];
	logic [hsv_pkg::CHANNEL_BITS-1:0] den_s  [hsv_pkg::DIV_QW-1];

	// One restoring step per stage; the quotient bits shift in at the bottom of the accumulator.
	always_comb begin
		acc_in[0] = op.num;
		den_in[0] = op.den;
		for (int j = 1; j < hsv_pkg::DIV_QW; j++) begin
			acc_in[j] = acc_s[j-1];
			den_in[j] = den_s[j-1];
		end
		for (int j = 0; j < hsv_pkg::DIV_QW; j++) begin
			trial[j] = {acc_in[j][hsv_pkg::DIV_NW-1:hsv_pkg::DIV_QW],
				acc_in[j][hsv_pkg::DIV_QW-1]};
			ge[j]    = trial[j] >= {1'b0, den_in[j]};
			rem[j]   = ge[j] ? (trial[j] - {1'b0, den_in[j]}) : trial[j];
			acc_nx[j] = {rem[j][hsv_pkg::CHANNEL_BITS-1:0],
				acc_in[j][hsv_pkg::DIV_QW-2:0], ge[j]};
		end
	end

	for (genvar j = 0; j < hsv_pkg::DIV_QW; j++) begin : g_stage
		always_ff @(posedge clk) begin
			if (ctl.en[hsv_pkg::DIV_BASE + j]) begin
				acc_s[j] <= acc_nx[j];
			end
		end
		if (j < hsv_pkg::DIV_QW - 1) begin : g_den
			always_ff @(posedge clk) begin
				if (ctl.en[hsv_pkg::DIV_BASE + j]) begin
					den_s[j] <= den_in[j];
				end
			end
		end
	end

	assign quo = acc_s[hsv_pkg::DIV_QW-1][hsv_pkg::DIV_QW-1:0];

endmodule
